// ----- sv/dwvd_pkg.sv -----
// Package for the deque with value delete: sizes, request and status codes,
// and the control struct that the top level sends to every storage cell.
// No dependencies.
package dwvd_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 24;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = 7;
    localparam int TOTAL_W     = 30;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_FRONT  = 3'd1,
        REQ_BACK   = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_STATUS = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic                   load;
        logic                   front;
        logic                   del;
        logic [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]       count;
        logic [CNT_W-1:0]       back_pos;
    } cell_ctrl_t;

endpackage

// ----- sv/dwvd_req_if.sv -----
// Request channel interface: valid/ready handshake with request payload.
// Depends on dwvd_pkg for field widths.
interface dwvd_req_if;
    logic                             valid;
    logic                             ready;
    logic [dwvd_pkg::REQ_W-1:0]       req_type;
    logic [dwvd_pkg::VALUE_WIDTH-1:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

// ----- sv/dwvd_rsp_if.sv -----
// Response channel interface: valid/ready handshake with result payload.
// Depends on dwvd_pkg for field widths.
interface dwvd_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [dwvd_pkg::VALUE_WIDTH-1:0] removed_value;
    logic [dwvd_pkg::STATUS_W-1:0]    status;
    logic [dwvd_pkg::CNT_W-1:0]       entry_count;
    logic [dwvd_pkg::TOTAL_W-1:0]     total_value;

    modport source (output valid, output removed_value, output status,
                    output entry_count, output total_value, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input entry_count, input total_value, output ready);
endinterface

// ----- sv/dwvd_cell.sv -----
// One storage cell of the deque: holds a value, loads it on an append at the tail,
// compares it for deletion and shifts in its right neighbor's value when it or an earlier entry leaves.
// Depends on dwvd_pkg.
module dwvd_cell (
    input  logic                             clk,
    input  dwvd_pkg::cell_ctrl_t             ctrl,
    input  logic [dwvd_pkg::IDX_W-1:0]       idx,
    input  logic [dwvd_pkg::VALUE_WIDTH-1:0] next_value,
    input  logic                             seen_in,
    output logic                             seen_out,
    output logic [dwvd_pkg::VALUE_WIDTH-1:0] value,
    output logic [dwvd_pkg::VALUE_WIDTH-1:0] tap
);
    import dwvd_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   occupied;
    logic                   at_tail;
    logic                   hit;

    always_comb
    begin
        occupied = CNT_W'(idx) < ctrl.count;
        at_tail  = CNT_W'(idx) == ctrl.count;
        // The first matching occupied cell, or the head on a front removal,
        // starts the shift; every cell after it takes its neighbor's value.
        hit      = (ctrl.del && occupied && (value_reg == ctrl.value))
                 || (ctrl.front && (idx == '0));
        seen_out = seen_in || hit;

        value_next = value_reg;
        if (ctrl.load && at_tail)
        begin
            value_next = ctrl.value;
        end
        else if (seen_out)
        begin
            value_next = next_value;
        end

        tap = (CNT_W'(idx) == ctrl.back_pos) ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- sv/deque_with_value_delete_top.sv -----
// Deque with value delete: a chain of DEPTH cells plus count and total registers.
// Response valid is registered and rises in the cycle after the request transaction.
// Throughput: one request transaction per cycle while the response side keeps up.
// The cell chain does all its compares and shifts in the cycle of acceptance.
// Reset (rst_n, asynchronous, active low) clears the count, the running total
// and the response valid; the cell contents are not reset.
module deque_with_value_delete_top (
    input  logic        clk,
    input  logic        rst_n,
    dwvd_req_if.sink    req,
    dwvd_rsp_if.source  rsp
);
    import dwvd_pkg::*;

    // Architectural state outside the cells.
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;

    // Response register. It frees as soon as the sink takes the transaction,
    // so a new request is taken in the same cycle.
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [VALUE_WIDTH-1:0] removed_reg;
    logic [VALUE_WIDTH-1:0] removed_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;

    logic                   accept;
    logic                   is_append;
    logic                   is_front;
    logic                   is_back;
    logic                   is_delete;
    logic                   full;
    logic                   empty;
    logic                   found;
    logic [VALUE_WIDTH-1:0] back_value;

    cell_ctrl_t             ctrl;

    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_tap   [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_next  [DEPTH];
    logic                   seen       [DEPTH+1];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Request decode. Codes five to seven fall through as a status read.
    always_comb
    begin
        is_append = 1'b0;
        is_front  = 1'b0;
        is_back   = 1'b0;
        is_delete = 1'b0;
        unique case (req.req_type)
            REQ_APPEND: is_append = accept;
            REQ_FRONT:  is_front  = accept;
            REQ_BACK:   is_back   = accept;
            REQ_DELETE: is_delete = accept;
            default:    ;
        endcase
    end

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;

    // Control broadcast to every cell. Requests that cannot proceed are masked
    // so that the cells keep their contents.
    always_comb
    begin
        ctrl.load     = is_append && !full;
        ctrl.front    = is_front && !empty;
        ctrl.del      = is_delete;
        ctrl.value    = req.item_value;
        ctrl.count    = count_reg;
        ctrl.back_pos = count_reg - CNT_W'(1);
    end

    // The "seen" signal ripples from the head toward the tail; once a cell has
    // found the deleted entry, it and all later cells shift one place forward.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_last
            assign cell_next[i] = cell_value[i];
        end
        else
        begin : g_mid
            assign cell_next[i] = cell_value[i+1];
        end

        dwvd_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (IDX_W'(i)),
            .next_value (cell_next[i]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .value      (cell_value[i]),
            .tap        (cell_tap[i])
        );
    end

    assign found = seen[DEPTH];

    // Only the back cell drives a nonzero tap, so an OR gathers its value.
    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | cell_tap[i];
        end
    end

    // Status, removed value, count and total for the accepted request.
    always_comb
    begin
        status_next  = ST_OK;
        removed_next = '0;
        count_next   = count_reg;
        total_next   = total_reg;

        if (is_append)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                total_next = total_reg + TOTAL_W'(req.item_value);
            end
        end
        else if (is_front || is_back)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                removed_next = is_front ? cell_value[0] : back_value;
                count_next   = count_reg - CNT_W'(1);
                total_next   = total_reg - TOTAL_W'(removed_next);
            end
        end
        else if (is_delete)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (!found)
            begin
                status_next = ST_NOT_FOUND;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                total_next = total_reg - TOTAL_W'(req.item_value);
            end
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
        end
    end

    // Count and total registers already hold the post-request values, and they
    // change only on a new transaction, which also replaces the response.
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.status        = status_reg;
    assign rsp.entry_count   = count_reg;
    assign rsp.total_value   = total_reg;

endmodule

// ----- sv/dwvd_checker.sv -----
// Port-level checker for the deque with value delete, bound to the top level.
// Depends on dwvd_pkg and deque_with_value_delete_top.
module dwvd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [dwvd_pkg::VALUE_WIDTH-1:0] removed_value,
    input logic [dwvd_pkg::STATUS_W-1:0]    status,
    input logic [dwvd_pkg::CNT_W-1:0]       entry_count,
    input logic [dwvd_pkg::TOTAL_W-1:0]     total_value
);
    import dwvd_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(removed_value)
        && $stable(status) && $stable(entry_count) && $stable(total_value))
        else $error("response changed while stalled");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request gave no response");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> entry_count == CNT_W'(DEPTH))
        else $error("full status with store not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> entry_count == '0
        && removed_value == '0 && total_value == '0)
        else $error("empty status with entries present");

endmodule

bind deque_with_value_delete_top dwvd_checker u_dwvd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .removed_value (rsp.removed_value),
    .status        (rsp.status),
    .entry_count   (rsp.entry_count),
    .total_value   (rsp.total_value)
);
